@@ design/mcs_pkg.sv @@
// Package with the constants, phase codes and register indexes of the motor cycle sequencer.
package mcs_pkg;

    localparam int unsigned CfgWidth   = 14;
    localparam int unsigned CfgCount   = 8;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned RpmWidth   = 14;
    localparam int unsigned TimerWidth = 14;
    localparam int unsigned CountWidth = 32;
    localparam int unsigned ModWidth   = 4;
    localparam int unsigned PhaseWidth = 3;
    localparam int unsigned DutyWidth  = 7;
    localparam int unsigned InDataW    = 16;
    localparam int unsigned OutDataW   = 48;

    typedef logic [CfgWidth-1:0]   cfg_word_t;
    typedef logic [TimerWidth-1:0] timer_t;
    typedef logic [PhaseWidth-1:0] phase_t;
    typedef logic [DutyWidth-1:0]  duty_t;

    // Phase codes.
    localparam phase_t PH_RESET  = 3'd0;
    localparam phase_t PH_FWD    = 3'd1;
    localparam phase_t PH_SPAUSE = 3'd2;
    localparam phase_t PH_BWD    = 3'd3;
    localparam phase_t PH_EPAUSE = 3'd4;
    localparam phase_t PH_ERROR  = 3'd5;

    // Register indexes.
    localparam logic [CfgIdxW-1:0] CFG_RESET_HALF  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_FORWARD     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SHORT_PAUSE = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_BACKWARD    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_END_PAUSE   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_CHECK_DELAY = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_COOLDOWN    = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_MIN_RPM     = 3'd7;

    // Register values after reset.
    localparam cfg_word_t RST_RESET_HALF  = 14'd30;
    localparam cfg_word_t RST_FORWARD     = 14'd30;
    localparam cfg_word_t RST_SHORT_PAUSE = 14'd10;
    localparam cfg_word_t RST_BACKWARD    = 14'd35;
    localparam cfg_word_t RST_END_PAUSE   = 14'd50;
    localparam cfg_word_t RST_CHECK_DELAY = 14'd10;
    localparam cfg_word_t RST_COOLDOWN    = 14'd6000;
    localparam cfg_word_t RST_MIN_RPM     = 14'd100;

    // Fixed drive duties and cycle constants.
    localparam duty_t DUTY_RESET = 7'd99;
    localparam duty_t DUTY_FWD   = 7'd70;
    localparam duty_t DUTY_BWD   = 7'd64;
    localparam duty_t DUTY_OFF   = 7'd0;
    localparam timer_t STALL_WINDOW_END = 14'd20;
    localparam timer_t TIMER_MAX        = 14'h3FFF;
    localparam logic [ModWidth-1:0] SAVE_LAST = 4'd11;

endpackage

@@ design/motor_cycle_sequencer.sv @@
// Top level of the motor cycle sequencer: tick input, phase logic and result register.
//
// One input transfer is one 100 ms tick: s_tdata carries the measured speed and the
// pause switch. For every accepted tick the block returns exactly one result transfer
// on the m_ channel with the phase after the tick, the drive command (direction, duty,
// in_motion), the error display flag, the completed-cycle count and a save request
// that pulses on every twelfth completed cycle.
// The tick first lands in an input register; the phase and timer update is a short
// block of compares and counter steps between that register and the result register.
// The result is registered and offered from the result register; a new tick is taken
// in every cycle while m_tready stays high, so the sustained rate is one tick per cycle.
// The phase, timer and cycle counters advance when a tick moves from the input
// register into the result register, so ticks are handled strictly in order.
// When the receiver holds m_tready low, the result stays in the output register and
// the input register still takes one more tick; s_tready falls only when both are full.
// The configuration port writes one of eight 14-bit limit registers per cycle with
// cfg_wr_en; it is meant to be used only while no tick is in flight.
// Synchronous reset (aresetn low) empties both registers, loads the default limits,
// puts the sequence at the start of the first reset run and clears all counters.
module motor_cycle_sequencer
    import mcs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Input ticks.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // [13:0] measured_rpm, [14] paused, [15] zero
    // Results.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // [2:0] phase, [3] direction,
                                           // [10:4] duty_percent, [11] in_motion,
                                           // [12] show_error, [44:13] cycle_count,
                                           // [45] save_request, [47:46] zero
    // Configuration writes.
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgWidth-1:0] cfg_wdata
);

    // Limit registers.
    cfg_word_t cfg_reg [CfgCount];

    // Input register.
    logic                in_vld_reg;
    logic [RpmWidth-1:0] in_rpm_reg;
    logic                in_paused_reg;

    // Sequence state.
    phase_t                phase_reg;
    timer_t                timer_reg;
    logic [CountWidth-1:0] cycles_reg;
    logic [ModWidth-1:0]   mod12_reg;

    // Result register.
    logic                out_vld_reg;
    logic [OutDataW-1:0] out_data_reg;

    // Combinational next values.
    phase_t                phase_next;
    timer_t                timer_next;
    logic [CountWidth-1:0] cycles_next;
    logic [ModWidth-1:0]   mod12_next;
    logic                  dir;
    duty_t                 duty;
    logic                  motion;
    logic                  save;
    logic                  advance;

    // Sums of the reset run are formed one bit wider so they cannot wrap.
    logic [CfgWidth:0] half_twice;
    logic [CfgWidth:0] half_plus_chk;
    logic [CfgWidth:0] timer_wide;
    logic              slow;
    logic              in_window;

    // A tick leaves the input register when the result register is free or being drained.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[CFG_RESET_HALF]  <= RST_RESET_HALF;
            cfg_reg[CFG_FORWARD]     <= RST_FORWARD;
            cfg_reg[CFG_SHORT_PAUSE] <= RST_SHORT_PAUSE;
            cfg_reg[CFG_BACKWARD]    <= RST_BACKWARD;
            cfg_reg[CFG_END_PAUSE]   <= RST_END_PAUSE;
            cfg_reg[CFG_CHECK_DELAY] <= RST_CHECK_DELAY;
            cfg_reg[CFG_COOLDOWN]    <= RST_COOLDOWN;
            cfg_reg[CFG_MIN_RPM]     <= RST_MIN_RPM;
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_rpm_reg    <= s_tdata[RpmWidth-1:0];
            in_paused_reg <= s_tdata[RpmWidth];
        end
    end

    assign half_twice    = {1'b0, cfg_reg[CFG_RESET_HALF]} + {1'b0, cfg_reg[CFG_RESET_HALF]};
    assign half_plus_chk = {1'b0, cfg_reg[CFG_RESET_HALF]} + {1'b0, cfg_reg[CFG_CHECK_DELAY]};
    assign timer_wide    = {1'b0, timer_reg};
    assign slow          = in_rpm_reg < cfg_reg[CFG_MIN_RPM];
    // The run phases only check for a stall between the check delay and tick 20.
    assign in_window     = (timer_reg > cfg_reg[CFG_CHECK_DELAY]) &&
                           (timer_reg < STALL_WINDOW_END);

    always_comb begin
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        cycles_next = cycles_reg;
        mod12_next  = mod12_reg;
        dir         = 1'b0;
        duty        = DUTY_OFF;
        motion      = 1'b0;
        save        = 1'b0;

        // A paused tick freezes the phase and the timer and stops the motor.
        if (!in_paused_reg) begin
            case (phase_reg)
                PH_RESET: begin
                    if (timer_reg <= cfg_reg[CFG_RESET_HALF]) begin
                        // Forward half of the first reset run.
                        dir    = 1'b1;
                        duty   = DUTY_RESET;
                        motion = 1'b1;
                        if (timer_reg > cfg_reg[CFG_CHECK_DELAY] && slow) begin
                            phase_next = PH_ERROR;
                        end
                    end else if (timer_wide <= half_twice) begin
                        // Backward half of the first reset run.
                        duty   = DUTY_RESET;
                        motion = 1'b1;
                        if (timer_wide > half_plus_chk && slow) begin
                            phase_next = PH_ERROR;
                        end
                    end else begin
                        phase_next = PH_FWD;
                    end
                end
                PH_FWD: begin
                    if (timer_reg <= cfg_reg[CFG_FORWARD]) begin
                        dir    = 1'b1;
                        duty   = DUTY_FWD;
                        motion = 1'b1;
                        if (in_window && slow) begin
                            phase_next = PH_ERROR;
                        end
                    end else begin
                        phase_next = PH_SPAUSE;
                    end
                end
                PH_SPAUSE: begin
                    if (timer_reg > cfg_reg[CFG_SHORT_PAUSE]) begin
                        phase_next = PH_BWD;
                    end
                end
                PH_BWD: begin
                    if (timer_reg <= cfg_reg[CFG_BACKWARD]) begin
                        duty   = DUTY_BWD;
                        motion = 1'b1;
                        if (in_window && slow) begin
                            phase_next = PH_ERROR;
                        end
                    end else begin
                        // The end of a backward run completes one cycle.
                        phase_next  = PH_EPAUSE;
                        cycles_next = cycles_reg + 1'b1;
                        if (mod12_reg >= SAVE_LAST) begin
                            mod12_next = '0;
                            save       = 1'b1;
                        end else begin
                            mod12_next = mod12_reg + 1'b1;
                        end
                    end
                end
                PH_EPAUSE: begin
                    if (timer_reg > cfg_reg[CFG_END_PAUSE]) begin
                        phase_next = PH_FWD;
                    end
                end
                PH_ERROR: begin
                    if (timer_reg > cfg_reg[CFG_COOLDOWN]) begin
                        phase_next = PH_RESET;
                    end
                end
                default: begin
                    // An unused phase code restarts the first reset run.
                    phase_next = PH_RESET;
                    dir        = 1'b1;
                    duty       = DUTY_RESET;
                    motion     = 1'b1;
                end
            endcase

            // The tick that detects a stall already stops the motor.
            if (phase_next == PH_ERROR && phase_reg != PH_ERROR) begin
                dir    = 1'b0;
                duty   = DUTY_OFF;
                motion = 1'b0;
            end

            // Entering a phase clears the timer; otherwise it counts up and saturates.
            if (phase_next != phase_reg) begin
                timer_next = '0;
            end else if (timer_reg != TIMER_MAX) begin
                timer_next = timer_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_RESET;
            timer_reg  <= '0;
            cycles_reg <= '0;
            mod12_reg  <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            cycles_reg <= cycles_next;
            mod12_reg  <= mod12_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {2'b00, save, cycles_next, (phase_next == PH_ERROR),
                             motion, duty, dir, phase_next};
        end
    end

    // A save request only goes out on the tick that enters the end pause.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[45]) |-> (m_tdata[2:0] == PH_EPAUSE))
        else $error("save request outside the end pause entry");

    // A commanded run always carries a nonzero duty, and a stop carries none.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11] == (m_tdata[10:4] != DUTY_OFF)))
        else $error("duty and in_motion disagree");

    // A paused tick leaves the phase and the timer untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_paused_reg) |=> ($stable(phase_reg) && $stable(timer_reg)))
        else $error("sequence moved on a paused tick");

    // The cycle count only moves when a backward run ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !(phase_reg == PH_BWD && phase_next == PH_EPAUSE))
            |=> $stable(cycles_reg))
        else $error("cycle count changed outside a cycle end");

endmodule

@@ verif/motor_cycle_sequencer_tb.sv @@
// Self-checking testbench of the motor cycle sequencer: directed and random tick streams.
`timescale 1ns / 1ps

// Every tick sent on the s_ channel is run through a model of the phase sequencer
// kept in this module, and the outputs that the model gives are queued. Each result
// transfer on the m_ channel is compared field by field with the oldest queued entry.
//
// The tests run in order from one initial block:
//   - reset values: default limits, speed and pause extremes, the speed threshold
//     boundary and a stall in the forward half of the first reset run;
//   - stall windows: the edges of the stall check in both reset halves and in both
//     run phases, including the end of the check window at tick 20;
//   - cycle count and save: short limits so that completed runs wrap the count of
//     twelve, and the save request pulses when it wraps;
//   - timer saturation: a reset half so long that its backward half can never end,
//     held until the phase timer sits at its top, then left by a new limit;
//   - backpressure: the receiver holds off for a long stretch while ticks keep
//     coming, so the block fills up and drops s_tready;
//   - random sequences: several limit sets, the extremes among them, each followed
//     by a stream of ticks that is mostly well-formed running speed, with some
//     slow ticks, some pauses and some arbitrary values mixed in.
// Limits are only loaded once every queued result has come back and the block
// has gone quiet.
module motor_cycle_sequencer_tb;
    import mcs_pkg::*;

    localparam int unsigned RPM_TOP        = (1 << RpmWidth) - 1;
    localparam int unsigned IDLE_MAX       = 17;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned TICK_GUARD     = 20000;
    localparam int unsigned RANDOM_SETS    = 10;
    localparam int unsigned TICKS_PER_SET  = 200;

    // Outputs of one tick, one member per field of m_tdata.
    typedef struct {
        phase_t                phase;
        logic                  direction;
        duty_t                 duty_percent;
        logic                  in_motion;
        logic                  show_error;
        logic [CountWidth-1:0] cycle_count;
        logic                  save_request;
    } tick_outputs_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;    // [13:0] measured_rpm, [14] paused, [15] zero
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;    // [2:0] phase, [3] direction, [10:4] duty_percent,
                                     // [11] in_motion, [12] show_error,
                                     // [44:13] cycle_count, [45] save_request, [47:46] zero
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgWidth-1:0] cfg_wdata;

    // Sequencer state as the model sees it, and its copy of the limit registers.
    phase_t                seq_phase;
    timer_t                seq_timer;
    logic [CountWidth-1:0] seq_cycles;
    logic [ModWidth-1:0]   seq_mod_twelve;
    cfg_word_t             limits [CfgCount];

    tick_outputs_t sequencer_outputs_q [$];
    int unsigned   mismatch_count = 0;

    // Idle knobs: the most cycles each side waits per transfer (0 means no idling).
    int unsigned tx_gap_max = IDLE_MAX;
    int unsigned rx_wait_max = IDLE_MAX;

    // The test bumps hold_req; the receiver notices the change and holds off.
    int unsigned hold_req = 0;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned rx_wait;
    int unsigned quiet_cycles;

    motor_cycle_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------

    task automatic reset_model();
        limits[CFG_RESET_HALF]  = RST_RESET_HALF;
        limits[CFG_FORWARD]     = RST_FORWARD;
        limits[CFG_SHORT_PAUSE] = RST_SHORT_PAUSE;
        limits[CFG_BACKWARD]    = RST_BACKWARD;
        limits[CFG_END_PAUSE]   = RST_END_PAUSE;
        limits[CFG_CHECK_DELAY] = RST_CHECK_DELAY;
        limits[CFG_COOLDOWN]    = RST_COOLDOWN;
        limits[CFG_MIN_RPM]     = RST_MIN_RPM;
        seq_phase      = PH_RESET;
        seq_timer      = '0;
        seq_cycles     = '0;
        seq_mod_twelve = '0;
    endtask

    // Advances the sequencer by one tick and returns what the block should report.
    // The phase is judged with the timer value held before the tick.
    function automatic tick_outputs_t next_tick_outputs(input logic [RpmWidth-1:0] rpm,
                                                        input logic paused);
        int unsigned   t;
        int unsigned   half;
        int unsigned   chk;
        logic          slow;
        phase_t        nxt;
        logic          dir;
        duty_t         duty;
        logic          motion;
        logic          save;
        tick_outputs_t o;
        t      = seq_timer;
        half   = limits[CFG_RESET_HALF];
        chk    = limits[CFG_CHECK_DELAY];
        slow   = rpm < limits[CFG_MIN_RPM];
        nxt    = seq_phase;
        dir    = 1'b0;
        duty   = DUTY_OFF;
        motion = 1'b0;
        save   = 1'b0;
        // A paused tick freezes phase and timer and leaves the drive stopped.
        if (!paused) begin
            case (seq_phase)
                PH_RESET: begin
                    if (t <= half) begin
                        dir = 1'b1; duty = DUTY_RESET; motion = 1'b1;
                        if (t > chk && slow) nxt = PH_ERROR;
                    end else if (t <= half + half) begin
                        dir = 1'b0; duty = DUTY_RESET; motion = 1'b1;
                        if (t > half + chk && slow) nxt = PH_ERROR;
                    end else begin
                        nxt = PH_FWD;
                    end
                end
                PH_FWD: begin
                    if (t <= limits[CFG_FORWARD]) begin
                        dir = 1'b1; duty = DUTY_FWD; motion = 1'b1;
                        if (t > chk && t < STALL_WINDOW_END && slow) nxt = PH_ERROR;
                    end else begin
                        nxt = PH_SPAUSE;
                    end
                end
                PH_SPAUSE: begin
                    if (t > limits[CFG_SHORT_PAUSE]) nxt = PH_BWD;
                end
                PH_BWD: begin
                    if (t <= limits[CFG_BACKWARD]) begin
                        dir = 1'b0; duty = DUTY_BWD; motion = 1'b1;
                        if (t > chk && t < STALL_WINDOW_END && slow) nxt = PH_ERROR;
                    end else begin
                        // A finished backward run completes one cycle.
                        nxt = PH_EPAUSE;
                        seq_cycles = seq_cycles + 1'b1;
                        if (seq_mod_twelve >= SAVE_LAST) begin
                            seq_mod_twelve = '0;
                            save = 1'b1;
                        end else begin
                            seq_mod_twelve = seq_mod_twelve + 1'b1;
                        end
                    end
                end
                PH_EPAUSE: begin
                    if (t > limits[CFG_END_PAUSE]) nxt = PH_FWD;
                end
                PH_ERROR: begin
                    if (t > limits[CFG_COOLDOWN]) nxt = PH_RESET;
                end
                default: begin
                    // Unused codes behave as the start of the first reset run.
                    nxt = PH_RESET;
                    dir = 1'b1; duty = DUTY_RESET; motion = 1'b1;
                end
            endcase
            // The stall tick itself already shows a stopped motor.
            if (nxt == PH_ERROR && seq_phase != PH_ERROR) begin
                dir = 1'b0; duty = DUTY_OFF; motion = 1'b0;
            end
            if (nxt != seq_phase) begin
                seq_timer = '0;
            end else if (seq_timer < TIMER_MAX) begin
                seq_timer = seq_timer + 1'b1;
            end
            seq_phase = nxt;
        end
        o.phase        = seq_phase;
        o.direction    = dir;
        o.duty_percent = duty;
        o.in_motion    = motion;
        o.show_error   = (seq_phase == PH_ERROR);
        o.cycle_count  = seq_cycles;
        o.save_request = save;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready pattern, hold-off and checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result(input logic [OutDataW-1:0] d);
        tick_outputs_t want;
        if (sequencer_outputs_q.size() == 0) begin
            $error("result transfer 0x%0h arrived with no tick outstanding", d);
            mismatch_count++;
        end else begin
            want = sequencer_outputs_q.pop_front();
            check_field("phase", want.phase, d[2:0]);
            check_field("direction", want.direction, d[3]);
            check_field("duty_percent", want.duty_percent, d[10:4]);
            check_field("in_motion", want.in_motion, d[11]);
            check_field("show_error", want.show_error, d[12]);
            check_field("cycle_count", want.cycle_count, d[44:13]);
            check_field("save_request", want.save_request, d[45]);
            check_field("tdata padding", 0, d[47:46]);
        end
    endfunction

    // The receiver draws a random stall after every transfer. A new hold request
    // overrides that and keeps m_tready low until its hold counter, loaded from HOLD_CYCLES, runs down.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_wait   <= 0;
            hold_left <= 0;
            hold_seen <= 0;
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                int unsigned w;
                w = $urandom_range(rx_wait_max, 0);
                rx_wait  <= w;
                m_tready <= (w == 0);
            end else if (rx_wait > 0) begin
                rx_wait  <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tick side
    // ------------------------------------------------------------------

    // Offers one tick after a random gap and returns at the edge where it is taken.
    // s_tvalid stays high when the next tick follows with no gap.
    task automatic send_tick(input logic [RpmWidth-1:0] rpm, input logic paused);
        int unsigned gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, paused, rpm};
        do @(posedge aclk); while (!s_tready);
        sequencer_outputs_q.push_back(next_tick_outputs(rpm, paused));
    endtask

    // Waits until every tick has come back and the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sequencer_outputs_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Loads all eight limit registers, one write per cycle, with the block idle.
    task automatic load_limits(input int unsigned half, fwd, spause, bwd, epause,
                               chk, cooldown, rpm_min);
        cfg_word_t vals [CfgCount];
        vals[CFG_RESET_HALF]  = cfg_word_t'(half);
        vals[CFG_FORWARD]     = cfg_word_t'(fwd);
        vals[CFG_SHORT_PAUSE] = cfg_word_t'(spause);
        vals[CFG_BACKWARD]    = cfg_word_t'(bwd);
        vals[CFG_END_PAUSE]   = cfg_word_t'(epause);
        vals[CFG_CHECK_DELAY] = cfg_word_t'(chk);
        vals[CFG_COOLDOWN]    = cfg_word_t'(cooldown);
        vals[CFG_MIN_RPM]     = cfg_word_t'(rpm_min);
        settle();
        for (int i = 0; i < CfgCount; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= i[CfgIdxW-1:0];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            limits[i] = vals[i];
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [RpmWidth-1:0] running_rpm();
        return RpmWidth'($urandom_range(RPM_TOP, limits[CFG_MIN_RPM]));
    endfunction

    function automatic logic [RpmWidth-1:0] stalled_rpm();
        if (limits[CFG_MIN_RPM] == 0) return '0;
        return RpmWidth'($urandom_range(limits[CFG_MIN_RPM] - 1, 0));
    endfunction

    // Sends unpaused ticks until the model stands in the given phase with the
    // given timer value, so the next tick is judged exactly there.
    task automatic drive_to(input phase_t ph, input int unsigned tmr, input bit stall_fill);
        int unsigned n;
        n = 0;
        while (!(seq_phase == ph && seq_timer == tmr)) begin
            if (n == TICK_GUARD) begin
                $error("phase %0d with timer %0d never reached", ph, tmr);
                mismatch_count++;
                break;
            end
            send_tick(stall_fill ? stalled_rpm() : running_rpm(), 1'b0);
            n++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default limits: half 30, check delay 10, threshold 100. Speeds of zero are
    // harmless up to the check delay; a paused slow tick never stalls.
    task automatic test_reset_values();
        for (int i = 0; i <= 10; i++) begin
            send_tick((i % 2 == 1) ? RPM_TOP[RpmWidth-1:0] : '0, 1'b0);
            if (i == 5) send_tick('0, 1'b1);
        end
        send_tick('0, 1'b1);
        send_tick(RPM_TOP[RpmWidth-1:0], 1'b1);
        send_tick(RST_MIN_RPM, 1'b0);            // exactly at the threshold: still running
        send_tick(RST_MIN_RPM - 1'b1, 1'b0);     // just below it: stall into error
        send_tick(RST_MIN_RPM, 1'b0);
        send_tick('0, 1'b1);
    endtask

    task automatic test_stall_windows();
        load_limits(4, 25, 0, 25, 0, 2, 0, 1000);
        // Forward half of the reset run: no stall at the check delay itself.
        drive_to(PH_RESET, 2, 1'b0);
        send_tick(stalled_rpm(), 1'b0);
        // Backward half: the check starts after half plus the check delay.
        drive_to(PH_RESET, 6, 1'b0);
        send_tick(stalled_rpm(), 1'b0);
        send_tick(stalled_rpm(), 1'b0);
        // Forward run: no stall at the check delay, none once the window closes.
        drive_to(PH_FWD, 2, 1'b0);
        send_tick(stalled_rpm(), 1'b0);
        drive_to(PH_FWD, STALL_WINDOW_END, 1'b0);
        send_tick(stalled_rpm(), 1'b0);
        drive_to(PH_BWD, 3, 1'b0);
        send_tick(stalled_rpm(), 1'b0);
        // Last tick of the window in the forward run, then in the backward run.
        drive_to(PH_FWD, STALL_WINDOW_END - 1, 1'b0);
        send_tick(stalled_rpm(), 1'b0);
        drive_to(PH_BWD, STALL_WINDOW_END - 1, 1'b0);
        send_tick(stalled_rpm(), 1'b0);
        drive_to(PH_BWD, STALL_WINDOW_END, 1'b0);
        send_tick(stalled_rpm(), 1'b0);
        drive_to(PH_EPAUSE, 0, 1'b0);
    endtask

    // Minimal limits and no stall possible: a cycle takes a handful of ticks,
    // so thirteen of them are sure to wrap the count of twelve once.
    task automatic test_cycle_count_and_save();
        logic [CountWidth-1:0] start;
        load_limits(1, 1, 0, 1, 0, TIMER_MAX, 0, 0);
        start = seq_cycles;
        while (seq_cycles - start < 13)
            send_tick(RpmWidth'($urandom_range(RPM_TOP, 0)), $urandom_range(9, 0) == 0);
    endtask

    // With half 8192 the backward half would need a timer above 16384, so it
    // never ends and the timer saturates. A short half then lets it leave.
    task automatic test_timer_saturation();
        load_limits(1, 1, 0, 1, 0, 0, 0, TIMER_MAX);
        drive_to(PH_ERROR, 0, 1'b1);
        tx_gap_max  = 0;
        rx_wait_max = 0;
        load_limits(8192, 1, 0, 1, 0, 0, 0, 0);
        drive_to(PH_RESET, TIMER_MAX, 1'b0);
        repeat (5) send_tick(RpmWidth'($urandom_range(RPM_TOP, 0)), 1'b0);
        load_limits(1, 1, 0, 1, 0, 0, 0, 0);
        repeat (3) send_tick(RpmWidth'($urandom_range(RPM_TOP, 0)), 1'b0);
        settle();
        tx_gap_max  = IDLE_MAX;
        rx_wait_max = IDLE_MAX;
    endtask

    // The receiver holds off while ticks keep coming back to back.
    task automatic test_backpressure();
        tx_gap_max = 0;
        hold_req <= hold_req + 1;
        repeat (40) send_tick(running_rpm(), $urandom_range(7, 0) == 0);
        settle();
        tx_gap_max = IDLE_MAX;
    endtask

    function automatic int unsigned random_limit(input int unsigned lo);
        case ($urandom_range(9, 0))
            0:       return lo;
            1:       return TIMER_MAX;
            2:       return $urandom_range(TIMER_MAX, lo);
            default: return $urandom_range(12, lo);
        endcase
    endfunction

    task automatic test_random_sequences();
        int unsigned pick;
        logic [RpmWidth-1:0] rpm;
        for (int set = 0; set < RANDOM_SETS; set++) begin
            if (set == 0)
                load_limits(1, 1, 0, 1, 0, 0, 0, 0);
            else if (set == 1)
                load_limits(TIMER_MAX, TIMER_MAX, TIMER_MAX, TIMER_MAX, TIMER_MAX,
                            TIMER_MAX, TIMER_MAX, TIMER_MAX);
            else
                load_limits(random_limit(1), random_limit(1), random_limit(0),
                            random_limit(1), random_limit(0), random_limit(0),
                            random_limit(0), $urandom_range(9, 0) < 3 ?
                            $urandom_range(RPM_TOP, 0) : $urandom_range(400, 0));
            // One set runs without any idling on either side.
            tx_gap_max  = (set == 3) ? 0 : IDLE_MAX;
            rx_wait_max = (set == 3) ? 0 : IDLE_MAX;
            for (int n = 0; n < TICKS_PER_SET; n++) begin
                pick = $urandom_range(99, 0);
                if (pick < 8)
                    rpm = stalled_rpm();
                else if (pick < 12)
                    rpm = $urandom_range(1, 0) ? RPM_TOP[RpmWidth-1:0] : '0;
                else if (pick < 20)
                    rpm = RpmWidth'($urandom_range(RPM_TOP, 0));
                else
                    rpm = running_rpm();
                send_tick(rpm, $urandom_range(11, 0) == 0);
            end
        end
        settle();
        tx_gap_max  = IDLE_MAX;
        rx_wait_max = IDLE_MAX;
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        reset_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_stall_windows();
        test_cycle_count_and_save();
        test_timer_saturation();
        test_backpressure();
        test_random_sequences();

        settle();
        if (mismatch_count == 0 && sequencer_outputs_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
